@@ rtl/multi_slot_alarm_unit_defines.svh @@
// Assertion macros for the multi-slot alarm unit.
// Needs clk and rst_n in scope at the point of use.
`ifndef MULTI_SLOT_ALARM_UNIT_DEFINES_SVH
`define MULTI_SLOT_ALARM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MSAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MSAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/msau_pkg.sv @@
// Shared widths, codes and control structs for the multi-slot alarm unit.
// No dependencies.
`timescale 1ns / 1ps

package msau_pkg;

    // Field widths
    localparam int KIND_W   = 1;
    localparam int TIME_W   = 32;
    localparam int SLOTF_W  = 4;
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 20;
    localparam int WINDOW_W = 8;
    localparam int MASK_W   = 10;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd5;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 1'b0;
    localparam logic [KIND_W-1:0] KIND_SET  = 1'b1;

    // Slot modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd2;
    // not a real mode: set beats carrying it are dropped
    localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic write_slot;  // store a set beat into the slot table
        logic load_tick;   // latch time, clear mask, rewind slot counter
        logic step;        // evaluate current slot, advance counter
        logic load_out;    // move finished mask to the output register
    } msau_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_slot;
    } msau_status_t;

endpackage

@@ rtl/msau_if.sv @@
// Handshake channel interfaces for item and alert beats.
// Depends on msau_pkg for field widths.
`timescale 1ns / 1ps

interface msau_item_if;
    logic                           valid;
    logic                           ready;
    logic [msau_pkg::KIND_W-1:0]    kind;
    logic [msau_pkg::TIME_W-1:0]    now_seconds;
    logic [msau_pkg::SLOTF_W-1:0]   slot;
    logic [msau_pkg::MODE_W-1:0]    mode;
    logic [msau_pkg::TIME_W-1:0]    alarm_time;
    logic [msau_pkg::PERIOD_W-1:0]  period;

    modport source (
        output valid, kind, now_seconds, slot, mode, alarm_time, period,
        input  ready
    );
    modport sink (
        input  valid, kind, now_seconds, slot, mode, alarm_time, period,
        output ready
    );
endinterface

interface msau_alert_if;
    logic                         valid;
    logic                         ready;
    logic [msau_pkg::MASK_W-1:0]  alert_mask;

    modport source (
        output valid, alert_mask,
        input  ready
    );
    modport sink (
        input  valid, alert_mask,
        output ready
    );
endinterface

@@ rtl/msau_dp.sv @@
// Datapath: slot table, window register, walk counter and alert mask.
// Depends on msau_pkg; driven by msau_ctrl commands.
`timescale 1ns / 1ps

module msau_dp #(
    parameter int SLOT_COUNT = 10,
    parameter int SLOT_W     = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  msau_pkg::msau_cmd_t            cmd,
    output msau_pkg::msau_status_t         status,
    input  logic                           cfg_we,
    input  logic [msau_pkg::WINDOW_W-1:0]  cfg_wdata,
    input  logic [msau_pkg::TIME_W-1:0]    now_seconds,
    input  logic [msau_pkg::SLOTF_W-1:0]   slot,
    input  logic [msau_pkg::MODE_W-1:0]    mode,
    input  logic [msau_pkg::TIME_W-1:0]    alarm_time,
    input  logic [msau_pkg::PERIOD_W-1:0]  period,
    output logic [msau_pkg::MASK_W-1:0]    alert_mask
);
    import msau_pkg::*;

    logic [MODE_W-1:0]   slot_mode_reg [SLOT_COUNT];
    logic [TIME_W-1:0]   due_reg       [SLOT_COUNT];
    logic [PERIOD_W-1:0] period_reg    [SLOT_COUNT];

    logic [WINDOW_W-1:0] window_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-1:0]   out_mask_reg;

    logic                set_ok;
    logic [SLOT_W-1:0]   set_idx;
    logic [MODE_W-1:0]   cur_mode;
    logic [TIME_W-1:0]   cur_due;
    logic [PERIOD_W-1:0] cur_period;
    logic signed [TIME_W:0] diff;
    logic signed [TIME_W:0] win_pos;
    logic signed [TIME_W:0] win_neg;
    logic                enabled;
    logic                in_window;
    logic                expired;
    logic [MASK_W-1:0]   hit_bit;

    // Set beat decode: slot must exist and mode must be a real one
    assign set_ok  = ({1'b0, slot} < (SLOTF_W+1)'(SLOT_COUNT))
                     && (mode != MODE_BAD);
    assign set_idx = slot[SLOT_W-1:0];

    // Current slot of the walk
    assign cur_mode   = slot_mode_reg[idx_reg];
    assign cur_due    = due_reg[idx_reg];
    assign cur_period = period_reg[idx_reg];

    // Signed distance from due time and window compares
    assign diff      = $signed({1'b0, now_reg}) - $signed({1'b0, cur_due});
    assign win_pos   = $signed({{(TIME_W+1-WINDOW_W){1'b0}}, window_reg});
    assign win_neg   = -win_pos;
    assign enabled   = (cur_mode != MODE_OFF);
    assign in_window = (diff > win_neg) && (diff < win_pos);
    assign expired   = (diff > win_pos);
    // slots past the mask width shift out to zero
    assign hit_bit   = MASK_W'(1) << idx_reg;

    assign status.last_slot = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign alert_mask       = out_mask_reg;

    // Window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    // Slot modes: written by set beats, cleared when a one-shot expires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_mode_reg[i] <= MODE_OFF;
            end
        end
        else if (cmd.write_slot && set_ok)
        begin
            slot_mode_reg[set_idx] <= mode;
        end
        else if (cmd.step && enabled && !in_window && expired
                 && (cur_mode == MODE_ONCE))
        begin
            slot_mode_reg[idx_reg] <= MODE_OFF;
        end
    end

    // Due times and periods: partial writes per mode; an expired repeat slot advances by its period
    always_ff @(posedge clk)
    begin
        if (cmd.write_slot && set_ok)
        begin
            if ((mode == MODE_ONCE) || (mode == MODE_REPEAT))
            begin
                due_reg[set_idx] <= alarm_time;
            end
            if (mode == MODE_REPEAT)
            begin
                period_reg[set_idx] <= period;
            end
        end
        else if (cmd.step && enabled && !in_window && expired
                 && (cur_mode != MODE_ONCE))
        begin
            due_reg[idx_reg] <= cur_due + TIME_W'(cur_period);
        end
    end

    // Walk state: time, slot counter, mask under construction
    always_ff @(posedge clk)
    begin
        if (cmd.load_tick)
        begin
            now_reg  <= now_seconds;
            idx_reg  <= '0;
            mask_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (enabled && in_window)
            begin
                mask_reg <= mask_reg | hit_bit;
            end
        end
        if (cmd.load_out)
        begin
            out_mask_reg <= mask_reg;
        end
    end

endmodule

@@ rtl/msau_ctrl.sv @@
// Controller: accepts beats, sequences the slot walk, owns output valid.
// Depends on msau_pkg; commands msau_dp.
`timescale 1ns / 1ps

module msau_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [msau_pkg::KIND_W-1:0]  item_kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    output msau_pkg::msau_cmd_t          cmd,
    input  msau_pkg::msau_status_t       status
);
    import msau_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_kind == KIND_SET)
                    begin
                        cmd.write_slot = 1'b1;
                    end
                    else
                    begin
                        cmd.load_tick = 1'b1;
                        state_next    = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/multi_slot_alarm_unit.sv @@
// Top level of the multi-slot alarm unit: controller, datapath, assertions.
// Depends on msau_pkg, msau_if, msau_ctrl, msau_dp and the defines header.
// Channel | dir | beat                                   | handshake
// item    | in  | tick (now) or set (slot, mode, times)  | valid/ready
// alert   | out | alert_mask, one per tick               | valid/ready
// cfg     | in  | alert_window                           | cfg_we only
// A set beat is stored in its accept cycle; the next beat may follow at once.
// A tick goes through accept, a walk step per slot, and the output load.
// The walk evaluates one slot per cycle through a single subtract-and-compare.
// The alert register holds a finished mask; a stalled alert stops the next
// tick only at its output load. Reset clears all slot modes to disabled.
`timescale 1ns / 1ps
`include "multi_slot_alarm_unit_defines.svh"

module multi_slot_alarm_unit #(
    parameter int SLOT_COUNT = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    msau_item_if.sink                      item,
    msau_alert_if.source                   alert,
    input  logic                           cfg_we,
    input  logic [msau_pkg::WINDOW_W-1:0]  cfg_wdata
);
    import msau_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    msau_cmd_t    cmd;
    msau_status_t status;

    msau_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_kind  (item.kind),
        .out_valid  (alert.valid),
        .out_ready  (alert.ready),
        .cmd        (cmd),
        .status     (status)
    );

    msau_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .now_seconds (item.now_seconds),
        .slot        (item.slot),
        .mode        (item.mode),
        .alarm_time  (item.alarm_time),
        .period      (item.period),
        .alert_mask  (alert.alert_mask)
    );

    // A tick beat starts a walk, so nothing else is taken next cycle
    `MSAU_ASSERT_NEXT(a_tick_blocks, cmd.load_tick, !item.ready, "input open during walk")
    // A finished mask never overwrites one still waiting
    `MSAU_ASSERT_NOW(a_no_overwrite, cmd.load_out, !alert.valid || alert.ready, "alert lost")
    // Slot table writes never collide with the walk
    `MSAU_ASSERT_NOW(a_set_vs_walk, cmd.write_slot, !cmd.step && !cmd.load_out, "set during walk")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for multi_slot_alarm_unit: directed and random beats,
// with a slot-table predictor updated per accepted beat and an in-order alert checker.
// Depends on msau_pkg, msau_if and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

    import msau_pkg::*;

    localparam int SLOT_COUNT  = 10;
    localparam int PERIOD_MAX  = 863999;
    localparam int CYCLE_LIMIT = 250000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   now_seconds;
        logic [SLOTF_W-1:0]  slot;
        logic [MODE_W-1:0]   mode;
        logic [TIME_W-1:0]   alarm_time;
        logic [PERIOD_W-1:0] period;
    } alarm_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [WINDOW_W-1:0] cfg_wdata;

    msau_item_if  item_ch ();
    msau_alert_if alert_ch ();

    multi_slot_alarm_unit #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .alert     (alert_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor copy of the slot table and the window register
    logic [MODE_W-1:0]   tbl_mode   [SLOT_COUNT];
    logic [TIME_W-1:0]   tbl_due    [SLOT_COUNT];
    logic [PERIOD_W-1:0] tbl_period [SLOT_COUNT];
    logic [WINDOW_W-1:0] window_q;

    logic [MASK_W-1:0] pending_masks [$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    logic [TIME_W-1:0] now_cur;
    bit long_hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Walk every enabled slot for one tick; returns the alert mask
    function automatic logic [MASK_W-1:0] walk_table(input logic [TIME_W-1:0] now);
        logic [MASK_W-1:0] mask;
        longint diff;
        longint w;
        mask = '0;
        w = longint'(window_q);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (tbl_mode[i] == MODE_OFF)
                continue;
            diff = longint'(now) - longint'(tbl_due[i]);
            if (diff > -w && diff < w)
            begin
                if (i < MASK_W)
                    mask[i] = 1'b1;
            end
            else if (diff > w)
            begin
                if (tbl_mode[i] == MODE_ONCE)
                    tbl_mode[i] = MODE_OFF;
                else
                    tbl_due[i] = tbl_due[i] + TIME_W'(tbl_period[i]);
            end
        end
        return mask;
    endfunction

    // Update the table for one accepted beat, queue the mask a tick will bring
    function automatic void apply_beat(input alarm_beat_t b);
        if (b.kind == KIND_TICK)
            pending_masks.push_back(walk_table(b.now_seconds));
        else if (b.slot < SLOT_COUNT && b.mode != MODE_BAD)
        begin
            tbl_mode[b.slot] = b.mode;
            if (b.mode == MODE_ONCE || b.mode == MODE_REPEAT)
                tbl_due[b.slot] = b.alarm_time;
            if (b.mode == MODE_REPEAT)
                tbl_period[b.slot] = b.period;
        end
    endfunction

    function automatic alarm_beat_t tick_beat(input logic [TIME_W-1:0] now);
        alarm_beat_t b;
        b.kind        = KIND_TICK;
        b.now_seconds = now;
        b.slot        = SLOTF_W'($urandom);
        b.mode        = MODE_W'($urandom);
        b.alarm_time  = $urandom;
        b.period      = PERIOD_W'($urandom_range(0, PERIOD_MAX));
        return b;
    endfunction

    function automatic alarm_beat_t set_beat(input int slot, input logic [MODE_W-1:0] mode,
                                             input logic [TIME_W-1:0] due, input int period);
        alarm_beat_t b;
        b.kind        = KIND_SET;
        b.now_seconds = $urandom;
        b.slot        = SLOTF_W'(slot);
        b.mode        = mode;
        b.alarm_time  = due;
        b.period      = PERIOD_W'(period);
        return b;
    endfunction

    // Mostly ticks walking forward in time and alarms set near it,
    // with some out-of-range sets and far jumps of the clock
    function automatic alarm_beat_t random_beat();
        int unsigned r;
        int unsigned w;
        int off;
        logic [MODE_W-1:0] m;
        r = $urandom_range(0, 99);
        w = 32'(window_q);
        if (r < 55)
        begin
            if ($urandom_range(0, 19) == 0)
                now_cur = now_cur + $urandom_range(0, 3 * w + 40);
            else
                now_cur = now_cur + $urandom_range(0, 3);
            return tick_beat(now_cur);
        end
        else if (r < 85)
        begin
            off = int'($urandom_range(0, 3 * w + 16)) - int'(w + 4);
            m = ($urandom_range(0, 9) == 0) ? MODE_OFF
                : (($urandom_range(0, 1) == 0) ? MODE_ONCE : MODE_REPEAT);
            return set_beat($urandom_range(0, SLOT_COUNT - 1), m, now_cur + TIME_W'(off),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, PERIOD_MAX)
                                                        : $urandom_range(0, 2 * w + 8));
        end
        else if (r < 93)
            return set_beat($urandom_range(0, 15), MODE_W'($urandom), $urandom,
                            $urandom_range(0, PERIOD_MAX));
        else
        begin
            // far jump, sometimes just short of the 32-bit wrap
            if ($urandom_range(0, 2) == 0)
                now_cur = 32'hFFFF_FFFF - $urandom_range(0, 3 * w + 20);
            else
                now_cur = $urandom;
            return tick_beat(now_cur);
        end
    endfunction

    // Send one beat: bursts of random length separated by random gaps
    task automatic send_beat(input alarm_beat_t b);
        if (burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 4))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_ch.kind        <= b.kind;
        item_ch.now_seconds <= b.now_seconds;
        item_ch.slot        <= b.slot;
        item_ch.mode        <= b.mode;
        item_ch.alarm_time  <= b.alarm_time;
        item_ch.period      <= b.period;
        item_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        apply_beat(b);
    endtask

    // Stop sending and wait until every expected mask has arrived
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (SLOT_COUNT + 6) @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        window_q = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_beat(random_beat());
    endtask

    // Window edges, expiry, wrap, zero period, ignored sets (window 5)
    task automatic test_directed();
        send_beat(tick_beat(32'd0));
        send_beat(set_beat(0, MODE_ONCE, 32'd100, 0));
        send_beat(tick_beat(32'd95));
        send_beat(tick_beat(32'd96));
        send_beat(tick_beat(32'd104));
        send_beat(tick_beat(32'd105));
        send_beat(tick_beat(32'd106));
        send_beat(tick_beat(32'd100));
        send_beat(set_beat(9, MODE_REPEAT, 32'hFFFF_FFF0, 32));
        send_beat(tick_beat(32'hFFFF_FFF2));
        send_beat(tick_beat(32'hFFFF_FFFF));
        send_beat(tick_beat(32'hFFFF_FFFF));
        send_beat(tick_beat(32'h0000_002E));
        send_beat(set_beat(4, MODE_REPEAT, 32'd200, 0));
        send_beat(tick_beat(32'd210));
        send_beat(tick_beat(32'd201));
        send_beat(set_beat(10, MODE_ONCE, 32'd201, 0));
        send_beat(set_beat(15, MODE_REPEAT, 32'd201, 5));
        send_beat(set_beat(3, MODE_BAD, 32'd201, 5));
        send_beat(tick_beat(32'd201));
        send_beat(set_beat(4, MODE_OFF, 32'd0, 0));
        send_beat(set_beat(5, MODE_REPEAT, 32'd0, PERIOD_MAX));
        send_beat(set_beat(6, MODE_ONCE, 32'hFFFF_FFFF, 0));
        send_beat(tick_beat(32'd0));
        send_beat(tick_beat(32'd201));
    endtask

    // Zero window: never alerts, any positive lag expires
    task automatic test_zero_window();
        write_window(8'd0);
        now_cur = 32'd5000;
        send_beat(set_beat(1, MODE_ONCE, 32'd5000, 0));
        send_beat(set_beat(2, MODE_REPEAT, 32'd5000, 2));
        send_beat(tick_beat(32'd5000));
        send_beat(tick_beat(32'd5001));
        send_beat(tick_beat(32'd5002));
        send_random(40);
    endtask

    task automatic test_window_extremes();
        write_window(8'd255);
        now_cur = 32'h8000_0000;
        send_beat(set_beat(7, MODE_ONCE, 32'h8000_0000, 0));
        send_beat(tick_beat(32'h8000_0000 - 32'd254));
        send_beat(tick_beat(32'h8000_0000 + 32'd255));
        send_beat(tick_beat(32'h8000_0000 + 32'd256));
        send_random(40);
        write_window(8'd1);
        send_random(40);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        write_window(8'd5);
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            now_cur = now_cur + $urandom_range(0, 2);
            send_beat(tick_beat(now_cur));
        end
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 4; p++)
        begin
            write_window(WINDOW_W'($urandom_range(0, 255)));
            send_random(100);
        end
    endtask

    // Receiver: stall style changes now and then; long hold on request
    initial
    begin
        int unsigned hold_left;
        int unsigned style;
        int unsigned style_left;
        hold_left = 0;
        style = 0;
        style_left = 0;
        alert_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 150);
            end
            style_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                alert_ch.ready <= 1'b0;
            end
            else
                case (style)
                    0: alert_ch.ready <= 1'b1;
                    1: alert_ch.ready <= 1'($urandom_range(0, 1));
                    2: alert_ch.ready <= ($urandom_range(0, 4) == 0);
                    default: alert_ch.ready <= style_left[3];
                endcase
        end
    end

    // Compare each alert beat with the oldest expected mask
    initial
    begin
        logic [MASK_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && alert_ch.valid && alert_ch.ready)
            begin
                if (pending_masks.size() == 0)
                begin
                    $error("alert_mask: expected none, actual %h", alert_ch.alert_mask);
                    fail_count++;
                end
                else
                begin
                    want = pending_masks.pop_front();
                    if (alert_ch.alert_mask !== want)
                    begin
                        $error("alert_mask: expected %h, actual %h", want,
                               alert_ch.alert_mask);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count = 0;
        burst_left = 0;
        long_hold_req = 1'b0;
        now_cur = 32'd0;
        window_q = WINDOW_RESET;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            tbl_mode[i]   = MODE_OFF;
            tbl_due[i]    = '0;
            tbl_period[i] = '0;
        end
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_TICK;
        item_ch.now_seconds <= '0;
        item_ch.slot        <= '0;
        item_ch.mode        <= MODE_OFF;
        item_ch.alarm_time  <= '0;
        item_ch.period      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_window();
        test_window_extremes();
        test_backpressure();
        test_random_mix();
        drain_results();

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
